FILE: rtl/pmc_pkg.sv
// Shared types and constants for the polygon monotonicity check.
package pmc_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int TOTAL_W          = 11;
  localparam int REV_W            = 2;
  localparam logic [REV_W-1:0] REV_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'd0,
    ST_WALK   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    HEAD_UNSET = 2'd0,
    HEAD_UP    = 2'd1,
    HEAD_DOWN  = 2'd2
  } head_t;

  typedef struct packed {
    logic load;
    logic walk_init;
    logic rd_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_issue;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/pmc_ctrl.sv
// Controller state machine: load, walk, drain and result handoff.
module pmc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_vertex,
  input  pmc_pkg::sts_t sts,
  output logic          in_stall,
  output pmc_pkg::cmd_t cmd
);

  pmc_pkg::state_t state;
  pmc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    cmd.load      = 1'b0;
    cmd.walk_init = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.finish    = 1'b0;
    case (state)
      pmc_pkg::ST_LOAD: begin
        in_stall      = 1'b0;
        cmd.load      = in_valid;
        cmd.walk_init = in_valid && last_vertex;
        if (in_valid && last_vertex) begin
          state_next = pmc_pkg::ST_WALK;
        end
      end
      pmc_pkg::ST_WALK: begin
        cmd.rd_en = 1'b1;
        if (sts.last_issue) begin
          state_next = pmc_pkg::ST_DRAIN;
        end
      end
      pmc_pkg::ST_DRAIN: begin
        state_next = pmc_pkg::ST_FINISH;
      end
      pmc_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = pmc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = pmc_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/pmc_datapath.sv
// Datapath: vertex memories, peak tracking, edge walk and result register.
module pmc_datapath #(
  parameter int MAX_VERTICES = pmc_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pmc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pmc_pkg::cmd_t                 cmd,
  output pmc_pkg::sts_t                 sts,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          monotone_in_x,
  output logic                          monotone_in_y,
  output logic                          vertices_dropped,
  output logic [pmc_pkg::TOTAL_W-1:0]   vertex_total
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         overflow;
  logic                         overflow_next;
  logic [IDX_W-1:0]             peak_x_idx;
  logic [IDX_W-1:0]             peak_x_idx_next;
  logic signed [COORD_BITS-1:0] peak_x_val;
  logic signed [COORD_BITS-1:0] peak_x_val_next;
  logic [IDX_W-1:0]             peak_y_idx;
  logic [IDX_W-1:0]             peak_y_idx_next;
  logic signed [COORD_BITS-1:0] peak_y_val;
  logic signed [COORD_BITS-1:0] peak_y_val_next;
  logic                         store_ok;

  logic [IDX_W-1:0]             addr_x;
  logic [IDX_W-1:0]             addr_y;
  logic [CNT_W-1:0]             k;
  logic                         rvld;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic                         have_prev;

  pmc_pkg::head_t               head_x;
  pmc_pkg::head_t               head_x_next;
  pmc_pkg::head_t               head_y;
  pmc_pkg::head_t               head_y_next;
  pmc_pkg::head_t               want_x;
  pmc_pkg::head_t               want_y;
  logic [pmc_pkg::REV_W-1:0]    rev_x;
  logic [pmc_pkg::REV_W-1:0]    rev_x_next;
  logic [pmc_pkg::REV_W-1:0]    rev_y;
  logic [pmc_pkg::REV_W-1:0]    rev_y_next;

  logic [CNT_W+pmc_pkg::TOTAL_W-1:0] tot_ext;

  assign store_ok = (count != CNT_W'(MAX_VERTICES));
  assign tot_ext  = {{pmc_pkg::TOTAL_W{1'b0}}, count};

  assign sts.last_issue = (k == count);
  assign sts.out_busy   = out_valid && out_stall;

  // Load side: count, overflow flag, first-greatest peaks
  always_comb begin
    count_next      = count;
    overflow_next   = overflow;
    peak_x_idx_next = peak_x_idx;
    peak_x_val_next = peak_x_val;
    peak_y_idx_next = peak_y_idx;
    peak_y_val_next = peak_y_val;
    if (cmd.finish) begin
      count_next      = '0;
      overflow_next   = 1'b0;
      peak_x_idx_next = '0;
      peak_x_val_next = '0;
      peak_y_idx_next = '0;
      peak_y_val_next = '0;
    end else if (cmd.load) begin
      if (store_ok) begin
        count_next = count + CNT_W'(1);
        if ((count == '0) || (coord_x > peak_x_val)) begin
          peak_x_idx_next = count[IDX_W-1:0];
          peak_x_val_next = coord_x;
        end
        if ((count == '0) || (coord_y > peak_y_val)) begin
          peak_y_idx_next = count[IDX_W-1:0];
          peak_y_val_next = coord_y;
        end
      end else begin
        overflow_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflow   <= 1'b0;
      peak_x_idx <= '0;
      peak_x_val <= '0;
      peak_y_idx <= '0;
      peak_y_val <= '0;
    end else begin
      count      <= count_next;
      overflow   <= overflow_next;
      peak_x_idx <= peak_x_idx_next;
      peak_x_val <= peak_x_val_next;
      peak_y_idx <= peak_y_idx_next;
      peak_y_val <= peak_y_val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      mem_x[count[IDX_W-1:0]] <= coord_x;
      mem_y[count[IDX_W-1:0]] <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x <= mem_x[addr_x];
    rd_y <= mem_y[addr_y];
  end

  // Walk addresses: start at each peak, wrap at count
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      addr_x <= peak_x_idx_next;
      addr_y <= peak_y_idx_next;
      k      <= '0;
    end else if (cmd.rd_en) begin
      addr_x <= (CNT_W'(addr_x) == count - CNT_W'(1)) ? '0 : addr_x + IDX_W'(1);
      addr_y <= (CNT_W'(addr_y) == count - CNT_W'(1)) ? '0 : addr_y + IDX_W'(1);
      k      <= k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld      <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      rvld <= cmd.rd_en;
      if (cmd.walk_init) begin
        have_prev <= 1'b0;
      end else if (rvld) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rvld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  // Heading tracking; reversal count saturates at the limit
  always_comb begin
    head_x_next = head_x;
    rev_x_next  = rev_x;
    want_x      = (prev_x < rd_x) ? pmc_pkg::HEAD_UP : pmc_pkg::HEAD_DOWN;
    if (cmd.finish) begin
      head_x_next = pmc_pkg::HEAD_UNSET;
      rev_x_next  = '0;
    end else if (rvld && have_prev && (prev_x != rd_x)) begin
      if ((head_x != pmc_pkg::HEAD_UNSET) && (head_x != want_x) &&
          (rev_x != pmc_pkg::REV_LIMIT)) begin
        rev_x_next = rev_x + pmc_pkg::REV_W'(1);
      end
      head_x_next = want_x;
    end
  end

  always_comb begin
    head_y_next = head_y;
    rev_y_next  = rev_y;
    want_y      = (prev_y < rd_y) ? pmc_pkg::HEAD_UP : pmc_pkg::HEAD_DOWN;
    if (cmd.finish) begin
      head_y_next = pmc_pkg::HEAD_UNSET;
      rev_y_next  = '0;
    end else if (rvld && have_prev && (prev_y != rd_y)) begin
      if ((head_y != pmc_pkg::HEAD_UNSET) && (head_y != want_y) &&
          (rev_y != pmc_pkg::REV_LIMIT)) begin
        rev_y_next = rev_y + pmc_pkg::REV_W'(1);
      end
      head_y_next = want_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_x <= pmc_pkg::HEAD_UNSET;
      head_y <= pmc_pkg::HEAD_UNSET;
      rev_x  <= '0;
      rev_y  <= '0;
    end else begin
      head_x <= head_x_next;
      head_y <= head_y_next;
      rev_x  <= rev_x_next;
      rev_y  <= rev_y_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      monotone_in_x    <= (rev_x < pmc_pkg::REV_LIMIT);
      monotone_in_y    <= (rev_y < pmc_pkg::REV_LIMIT);
      vertices_dropped <= overflow;
      vertex_total     <= tot_ext[pmc_pkg::TOTAL_W-1:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_addr_in_poly: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (CNT_W'(addr_x) < count) && (CNT_W'(addr_y) < count))
    else $error("walk address outside stored polygon");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == '0) && !overflow && (rev_x == '0) && (rev_y == '0))
    else $error("polygon state not cleared after result");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/polygon_monotonicity_check.sv
// Top level of the polygon monotonicity check.
//
//   channel   direction  handshake            word
//   vertex    in         in_valid / in_stall   coord_x, coord_y, last_vertex
//   result    out        out_valid / out_stall monotone_in_x, monotone_in_y,
//                                              vertices_dropped, vertex_total
//
// Vertices load one per cycle while in_stall is low, into two coordinate memories.
// After the last vertex, in_stall stays high through n + 1 registered reads
// that walk both axes at once (n = stored vertices), a drain state and the
// result write, plus any wait for a stalled result register to empty.
// Reset clears control state only; memory contents are not cleared.
module polygon_monotonicity_check #(
  parameter int MAX_VERTICES = pmc_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pmc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         monotone_in_x,
  output logic                         monotone_in_y,
  output logic                         vertices_dropped,
  output logic [pmc_pkg::TOTAL_W-1:0]  vertex_total
);

  pmc_pkg::cmd_t cmd;
  pmc_pkg::sts_t sts;

  pmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_vertex (last_vertex),
    .sts         (sts),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  pmc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .monotone_in_x    (monotone_in_x),
    .monotone_in_y    (monotone_in_y),
    .vertices_dropped (vertices_dropped),
    .vertex_total     (vertex_total)
  );

endmodule

FILE: bench/polygon_monotonicity_check_tb.sv
// Self-checking bench for polygon_monotonicity_check: directed and random polygons, scored.
module polygon_monotonicity_check_tb;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_WORDS  = 950;
  localparam int QUIET_FROM    = 850;
  localparam int HOLD_CYCLES   = 300;
  localparam int REV_CEILING   = 2047;
  localparam int COORD_W       = pmc_pkg::COORD_BITS_DEF;
  localparam int TOT_W         = pmc_pkg::TOTAL_W;
  localparam int MAXV          = pmc_pkg::MAX_VERTICES_DEF;

  typedef enum {SHAPE_NOISE, SHAPE_MOUNTAIN, SHAPE_DENT, SHAPE_TIGHT} shape_t;

  typedef struct {
    logic             mono_x;
    logic             mono_y;
    logic             dropped;
    logic [TOT_W-1:0] total;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [COORD_W-1:0]  coord_x = '0;
  logic signed [COORD_W-1:0]  coord_y = '0;
  logic                       last_vertex = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       monotone_in_x;
  logic                       monotone_in_y;
  logic                       vertices_dropped;
  logic [TOT_W-1:0]           vertex_total;

  bit hold_wanted = 1'b0;
  bit quiet_tail  = 1'b0;
  int cycle_count = 0;

  polygon_monotonicity_check u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .last_vertex      (last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .monotone_in_x    (monotone_in_x),
    .monotone_in_y    (monotone_in_y),
    .vertices_dropped (vertices_dropped),
    .vertex_total     (vertex_total)
  );

  class polygon_verdict_board;
    int       xs [MAXV];
    int       ys [MAXV];
    int       count;
    int       peak_x;
    int       peak_y;
    int       peak_x_at;
    int       peak_y_at;
    bit       overflow;
    int       failures;
    verdict_t pending [$];

    function int reversals_along(bit use_y, int start, int n);
      pmc_pkg::head_t heading = pmc_pkg::HEAD_UNSET;
      pmc_pkg::head_t want;
      int    flips = 0;
      int    a, b, i, j;
      for (int k = 0; k < n; k++) begin
        i = (start + k) % n;
        j = (i + 1) % n;
        a = use_y ? ys[i] : xs[i];
        b = use_y ? ys[j] : xs[j];
        if (a != b) begin
          want = (a < b) ? pmc_pkg::HEAD_UP : pmc_pkg::HEAD_DOWN;
          if (heading != pmc_pkg::HEAD_UNSET && heading != want && flips < REV_CEILING)
            flips++;
          heading = want;
        end
      end
      return flips;
    endfunction

    function void add_vertex(int x, int y, bit last);
      verdict_t v;
      if (count < MAXV) begin
        xs[count] = x;
        ys[count] = y;
        if (count == 0 || x > peak_x) begin
          peak_x    = x;
          peak_x_at = count;
        end
        if (count == 0 || y > peak_y) begin
          peak_y    = y;
          peak_y_at = count;
        end
        count++;
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        v.mono_x  = reversals_along(1'b0, peak_x_at, count) < int'(pmc_pkg::REV_LIMIT);
        v.mono_y  = reversals_along(1'b1, peak_y_at, count) < int'(pmc_pkg::REV_LIMIT);
        v.dropped = overflow;
        v.total   = TOT_W'(count);
        pending.insert(pending.size(), v);
        count     = 0;
        peak_x    = 0;
        peak_y    = 0;
        peak_x_at = 0;
        peak_y_at = 0;
        overflow  = 1'b0;
      end
    endfunction

    function void check_verdict(logic mx, logic my, logic dr, logic [TOT_W-1:0] tot);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: vertex_total %0d", tot);
        failures++;
      end else begin
        e = pending.pop_front();
        if (mx !== e.mono_x) begin
          $error("monotone_in_x: expected %0b, got %0b", e.mono_x, mx);
          failures++;
        end
        if (my !== e.mono_y) begin
          $error("monotone_in_y: expected %0b, got %0b", e.mono_y, my);
          failures++;
        end
        if (dr !== e.dropped) begin
          $error("vertices_dropped: expected %0b, got %0b", e.dropped, dr);
          failures++;
        end
        if (tot !== e.total) begin
          $error("vertex_total: expected %0d, got %0d", e.total, tot);
          failures++;
        end
      end
    endfunction
  endclass

  polygon_verdict_board board = new;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      board.check_verdict(monotone_in_x, monotone_in_y, vertices_dropped, vertex_total);
  end

  initial begin : result_sink
    int burst;
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_wanted = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_vertex(int x, int y, bit last);
    logic signed [COORD_W-1:0] xv;
    logic signed [COORD_W-1:0] yv;
    xv = COORD_W'(x);
    yv = COORD_W'(y);
    in_valid    <= 1'b1;
    coord_x     <= xv;
    coord_y     <= yv;
    last_vertex <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.add_vertex(int'(xv), int'(yv), last);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic send_polygon(int n, shape_t shape);
    int xs[];
    int ys[];
    int cx, cy, px, py, s, d;
    xs = new[n];
    ys = new[n];
    cx = int'($urandom_range(0, 56000)) - 28000;
    cy = int'($urandom_range(0, 56000)) - 28000;
    px = $urandom_range(0, n - 1);
    py = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_NOISE: begin
          xs[i] = $urandom;
          ys[i] = $urandom;
        end
        SHAPE_TIGHT: begin
          xs[i] = int'($urandom_range(0, 4)) - 2;
          ys[i] = int'($urandom_range(0, 4)) - 2;
        end
        default: begin
          // rise to a peak, then fall; steps of zero give flat runs
          xs[i] = cx;
          ys[i] = cy;
          s = $urandom_range(0, 3);
          cx += (i < px) ? s : -s;
          s = $urandom_range(0, 3);
          cy += (i < py) ? s : -s;
        end
      endcase
    end
    if (shape == SHAPE_DENT) begin
      d = $urandom_range(0, n - 1);
      xs[d] = $urandom;
      d = $urandom_range(0, n - 1);
      ys[d] = $urandom;
    end
    for (int i = 0; i < n; i++) send_vertex(xs[i], ys[i], i == n - 1);
  endtask

  initial begin : stimulus
    int     sent;
    int     polys;
    int     n;
    int     pick;
    shape_t shape;
    sent  = 0;
    polys = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone vertex at the coordinate extremes
    send_vertex(32767, -32768, 1'b1);
    // triangle spanning the full range
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, 0, 1'b0);
    send_vertex(0, 32767, 1'b1);
    // flat x, repeated points
    send_vertex(5, 5, 1'b0);
    send_vertex(5, 5, 1'b0);
    send_vertex(5, 7, 1'b0);
    send_vertex(5, 7, 1'b1);
    // square, ties on both maxima
    send_vertex(0, 0, 1'b0);
    send_vertex(10, 0, 1'b0);
    send_vertex(10, 10, 1'b0);
    send_vertex(0, 10, 1'b1);
    // zigzag in x, single turn in y
    for (int i = 0; i < 6; i++) send_vertex((i % 2) * 10, i, i == 5);

    while (sent < RANDOM_WORDS) begin
      if (polys == 40) hold_wanted = 1'b1;
      if (sent >= QUIET_FROM) quiet_tail = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 8)       shape = SHAPE_MOUNTAIN;
      else if (pick < 13) shape = SHAPE_DENT;
      else if (pick < 17) shape = SHAPE_TIGHT;
      else                shape = SHAPE_NOISE;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_polygon(n, shape);
      sent += n;
      polys++;
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pmc_pkg.sv
rtl/pmc_ctrl.sv
rtl/pmc_datapath.sv
rtl/polygon_monotonicity_check.sv
bench/polygon_monotonicity_check_tb.sv
